/* rtl/core/smc_pkg.sv */
// Package of the step and jump motion classifier: codes, constants and state encoding.
`default_nettype none

package smc_pkg;

  // Default depth of the sliding statistics window.
  localparam int unsigned WINDOW_LEN_DEF = 32;

  // EMA weights in Q.16: 34734 for the new sample, the remainder for the old value.
  localparam logic [15:0] ALPHA_NEW = 16'd34734;
  localparam logic [15:0] ALPHA_OLD = 16'd30802;
  localparam logic [31:0] EMA_ROUND = 32'd32768;

  // Idle band 0.9 g .. 1.1 g, decided on the squared magnitude.
  localparam logic [31:0] IDLE_LOW_SQ  = 32'd3397386;
  localparam logic [31:0] IDLE_HIGH_SQ = 32'd5075108;

  localparam logic [1:0]  LANDING_SAMPLES = 2'd3;
  localparam logic [15:0] ONE_G           = 16'd2048;

  // Last iteration indices of the shared shift-subtract unit.
  localparam logic [4:0] SQRT_LAST = 5'd15;
  localparam logic [4:0] VAR_LAST  = 5'd30;
  localparam logic [4:0] MEAN_LAST = 5'd15;

  // Register reset values.
  localparam logic [15:0] RST_ENTER    = 16'd614;
  localparam logic [15:0] RST_EXIT     = 16'd3072;
  localparam logic [15:0] RST_MIN_MS   = 16'd150;
  localparam logic [15:0] RST_MAX_MS   = 16'd800;
  localparam logic [9:0]  RST_K_GAIN   = 10'd256;
  localparam logic [15:0] RST_FLOOR    = 16'd2253;
  localparam logic [15:0] RST_CEILING  = 16'd5120;
  localparam logic [15:0] RST_HOLDOFF  = 16'd300;

  typedef enum logic [2:0] {
    REG_ENTER   = 3'd0,
    REG_EXIT    = 3'd1,
    REG_MIN_MS  = 3'd2,
    REG_MAX_MS  = 3'd3,
    REG_K_GAIN  = 3'd4,
    REG_FLOOR   = 3'd5,
    REG_CEILING = 3'd6,
    REG_HOLDOFF = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_IDLE  = 2'd0,
    CLS_STEP  = 2'd1,
    CLS_JUMP  = 2'd2,
    CLS_NOISE = 2'd3
  } motion_class_e;

  typedef enum logic [16:0] {
    ST_IDLE = 17'b00000000000000001,
    ST_SQX  = 17'b00000000000000010,
    ST_SQY  = 17'b00000000000000100,
    ST_SQZ  = 17'b00000000000001000,
    ST_RAW  = 17'b00000000000010000,
    ST_EMA1 = 17'b00000000000100000,
    ST_EMA2 = 17'b00000000001000000,
    ST_OLD  = 17'b00000000010000000,
    ST_PUSH = 17'b00000000100000000,
    ST_NQ   = 17'b00000001000000000,
    ST_TT   = 17'b00000010000000000,
    ST_NN   = 17'b00000100000000000,
    ST_VAR  = 17'b00001000000000000,
    ST_SD   = 17'b00010000000000000,
    ST_MEAN = 17'b00100000000000000,
    ST_KSD  = 17'b01000000000000000,
    ST_STEP = 17'b10000000000000000
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/smc_if.sv */
// Valid/ready channel interfaces for sample words and class words.
`default_nettype none

interface smc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic        [31:0] time_ms;

  modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface smc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] motion_class;

  modport source (output valid, motion_class, input ready);
  modport sink   (input valid, motion_class, output ready);
endinterface

`default_nettype wire

/* rtl/core/smc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module smc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/step_and_jump_motion_classifier_core.sv */
// Top level of the step and jump motion classifier: sequencer, shared units and registers.
//
// Usage. Samples (three signed Q.11 g axes and a millisecond timestamp) enter on the
// in_ch_i valid/ready channel; each accepted word yields exactly one class word
// (0 idle, 1 step, 2 jump, 3 noise) on the out_ch_o channel, in order.
// Sequence. From acceptance to the class word being offered, a sample passes through
// squaring of the three axes, the square root for the magnitude, the EMA and the window
// update, the window moments, the variance division, the deviation root, the mean
// division, and the threshold and decision. The sequencer then returns to idle, and no
// new sample is accepted before the last one has been through all of these steps. The
// pace is set by the single shift-subtract unit (one quotient or root bit per cycle)
// and the single multiplier.
// The input is ready only while the sequencer is idle.
// Stalls. The class word waits in an output register; the next sample is accepted while
// it waits. If the receiver still has not taken it when the next word is ready, the
// sequencer holds in its final state until the register frees.
// Reset. rst_ni clears the sequencer, the statistics, the flight and holdoff state and
// loads the register defaults. The window RAM needs no clearing: the fill count ensures
// that only written entries are ever used.
// Configuration. Eight registers of at most 16 bits, APB-style port, byte addresses 4*i;
// writes take effect at once and are meant to be made only while the block is idle.
`default_nettype none

module step_and_jump_motion_classifier_core #(
  parameter int unsigned WINDOW_LEN = smc_pkg::WINDOW_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  smc_in_if.sink           in_ch_i,
  smc_out_if.source        out_ch_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Widths that follow from the window depth.
  localparam int unsigned NW  = $clog2(WINDOW_LEN + 1);   // fill count
  localparam int unsigned HW  = $clog2(WINDOW_LEN);       // head index
  localparam int unsigned TW  = 16 + NW;                  // sum of entries
  localparam int unsigned QW  = 32 + NW;                  // sum of squares
  localparam int unsigned AW  = QW + NW;                  // accumulator
  localparam int unsigned PW  = QW + TW;                  // product
  localparam int unsigned UW  = (2 * NW + 1 > 19) ? 2 * NW + 1 : 19;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] enter_q, exit_q, min_ms_q, max_ms_q, floor_q, ceiling_q, holdoff_q;
  logic [9:0]  k_gain_q;
  logic        cfg_wr;
  smc_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = smc_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_q   <= smc_pkg::RST_ENTER;
      exit_q    <= smc_pkg::RST_EXIT;
      min_ms_q  <= smc_pkg::RST_MIN_MS;
      max_ms_q  <= smc_pkg::RST_MAX_MS;
      k_gain_q  <= smc_pkg::RST_K_GAIN;
      floor_q   <= smc_pkg::RST_FLOOR;
      ceiling_q <= smc_pkg::RST_CEILING;
      holdoff_q <= smc_pkg::RST_HOLDOFF;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        smc_pkg::REG_ENTER:   enter_q   <= pwdata[15:0];
        smc_pkg::REG_EXIT:    exit_q    <= pwdata[15:0];
        smc_pkg::REG_MIN_MS:  min_ms_q  <= pwdata[15:0];
        smc_pkg::REG_MAX_MS:  max_ms_q  <= pwdata[15:0];
        smc_pkg::REG_K_GAIN:  k_gain_q  <= pwdata[9:0];
        smc_pkg::REG_FLOOR:   floor_q   <= pwdata[15:0];
        smc_pkg::REG_CEILING: ceiling_q <= pwdata[15:0];
        smc_pkg::REG_HOLDOFF: holdoff_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      smc_pkg::REG_ENTER:   prdata = {16'd0, enter_q};
      smc_pkg::REG_EXIT:    prdata = {16'd0, exit_q};
      smc_pkg::REG_MIN_MS:  prdata = {16'd0, min_ms_q};
      smc_pkg::REG_MAX_MS:  prdata = {16'd0, max_ms_q};
      smc_pkg::REG_K_GAIN:  prdata = {22'd0, k_gain_q};
      smc_pkg::REG_FLOOR:   prdata = {16'd0, floor_q};
      smc_pkg::REG_CEILING: prdata = {16'd0, ceiling_q};
      smc_pkg::REG_HOLDOFF: prdata = {16'd0, holdoff_q};
      default:              prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------------
  smc_pkg::state_e state_q, state_d;

  logic [15:0]   ax_q, ay_q, az_q;       // absolute axis values
  logic [31:0]   t_q;
  logic [31:0]   s_q;                    // squared magnitude
  logic [15:0]   raw_q, smooth_q, ema_q, prior_q, older_q, sd_q, mean_q;
  logic [AW-1:0] acc_q;
  logic [2*NW-1:0] nn_q;
  logic [UW-1:0] rem_q;
  logic [31:0]   quo_q, feed_q;
  logic [4:0]    cnt_q;
  logic          jump_q;

  logic [NW-1:0] fill_q;
  logic [HW-1:0] head_q;
  logic [TW-1:0] total_q;
  logic [QW-1:0] sq_total_q;

  logic          airborne_q;
  logic [31:0]   flight_start_q, holdoff_end_q;
  logic [1:0]    exit_cnt_q;

  logic          out_valid_q;
  logic [1:0]    out_class_q;

  logic in_fire, out_free, full;

  assign in_ch_i.ready      = (state_q == smc_pkg::ST_IDLE);
  assign in_fire            = in_ch_i.valid && in_ch_i.ready;
  assign out_free           = !out_valid_q || out_ch_o.ready;
  assign out_ch_o.valid     = out_valid_q;
  assign out_ch_o.motion_class = out_class_q;
  assign full               = (fill_q == NW'(WINDOW_LEN));

  // ---------------------------------------------------------------------------
  // Window store
  // ---------------------------------------------------------------------------
  logic [15:0] old_entry;
  logic        ram_we;

  assign ram_we = (state_q == smc_pkg::ST_PUSH);

  smc_ram #(
    .WIDTH (16),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (smooth_q),
    .raddr_i (head_q),
    .rdata_o (old_entry)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier: operands are chosen by the sequencer state.
  // ---------------------------------------------------------------------------
  logic [QW-1:0] mul_a;
  logic [TW-1:0] mul_b;
  logic [PW-1:0] prod;

  always_comb begin
    case (state_q)
      smc_pkg::ST_SQX:  begin mul_a = QW'(ax_q);              mul_b = TW'(ax_q);     end
      smc_pkg::ST_SQY:  begin mul_a = QW'(ay_q);              mul_b = TW'(ay_q);     end
      smc_pkg::ST_SQZ:  begin mul_a = QW'(az_q);              mul_b = TW'(az_q);     end
      smc_pkg::ST_EMA1: begin mul_a = QW'(smc_pkg::ALPHA_NEW); mul_b = TW'(raw_q);   end
      smc_pkg::ST_EMA2: begin mul_a = QW'(smc_pkg::ALPHA_OLD); mul_b = TW'(ema_q);   end
      smc_pkg::ST_OLD:  begin mul_a = QW'(old_entry);         mul_b = TW'(old_entry); end
      smc_pkg::ST_PUSH: begin mul_a = QW'(smooth_q);          mul_b = TW'(smooth_q); end
      smc_pkg::ST_NQ:   begin mul_a = sq_total_q;             mul_b = TW'(fill_q);   end
      smc_pkg::ST_TT:   begin mul_a = QW'(total_q);           mul_b = total_q;       end
      smc_pkg::ST_NN:   begin mul_a = QW'(fill_q);            mul_b = TW'(fill_q);   end
      smc_pkg::ST_KSD:  begin mul_a = QW'(sd_q);              mul_b = TW'(k_gain_q); end
      default:          begin mul_a = '0;                     mul_b = '0;            end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // ---------------------------------------------------------------------------
  // Shared shift-subtract unit: one root bit (two radicand bits in) or one quotient
  // bit (one dividend bit in) per cycle.
  // ---------------------------------------------------------------------------
  logic          root_mode, unit_ge;
  logic [UW-1:0] unit_rs, unit_trial, rem_n;
  logic [31:0]   quo_n, feed_n;

  assign root_mode = (state_q == smc_pkg::ST_RAW) || (state_q == smc_pkg::ST_SD);

  always_comb begin
    if (root_mode) begin
      unit_rs    = {rem_q[UW-3:0], feed_q[31:30]};
      unit_trial = {quo_q[UW-3:0], 2'b01};
      feed_n     = {feed_q[29:0], 2'b00};
    end else begin
      unit_rs    = {rem_q[UW-2:0], feed_q[31]};
      unit_trial = (state_q == smc_pkg::ST_VAR) ? UW'(nn_q) : UW'(fill_q);
      feed_n     = {feed_q[30:0], 1'b0};
    end
    unit_ge = (unit_rs >= unit_trial);
    rem_n   = unit_ge ? (unit_rs - unit_trial) : unit_rs;
    quo_n   = {quo_q[30:0], unit_ge};
  end

  // ---------------------------------------------------------------------------
  // Per-state combinational results
  // ---------------------------------------------------------------------------
  logic [AW-1:0] ema_sum;
  logic [15:0]   smooth_n;
  logic [1:0]    exit_inc;
  logic          landing;
  logic [31:0]   flight_dur;
  logic [17:0]   thr, thr_clamped;
  logic          peak, step_hit;
  logic [1:0]    cls;

  assign ema_sum  = acc_q + AW'(prod) + AW'(smc_pkg::EMA_ROUND);
  assign smooth_n = ema_sum[31:16];

  // Landing needs three raw magnitudes in a row above the exit level.
  assign exit_inc   = (raw_q > exit_q)
                      ? ((exit_cnt_q < smc_pkg::LANDING_SAMPLES) ? exit_cnt_q + 2'd1
                                                                  : exit_cnt_q)
                      : 2'd0;
  assign landing    = (exit_inc >= smc_pkg::LANDING_SAMPLES);
  assign flight_dur = t_q - flight_start_q;

  // Adaptive threshold: mean + k*sd, clamped so that the floor wins an inversion.
  assign thr         = 18'(mean_q) + 18'(acc_q[AW-1:8]);
  always_comb begin
    thr_clamped = (thr < 18'(ceiling_q)) ? thr : 18'(ceiling_q);
    if (thr_clamped < 18'(floor_q)) begin
      thr_clamped = 18'(floor_q);
    end
  end

  assign peak     = (prior_q > older_q) && (prior_q > smooth_q);
  assign step_hit = peak && (18'(prior_q) > thr_clamped) && (t_q > holdoff_end_q);

  always_comb begin
    if (jump_q) begin
      cls = smc_pkg::CLS_JUMP;
    end else if (step_hit) begin
      cls = smc_pkg::CLS_STEP;
    end else if (s_q > smc_pkg::IDLE_LOW_SQ && s_q < smc_pkg::IDLE_HIGH_SQ) begin
      cls = smc_pkg::CLS_IDLE;
    end else begin
      cls = smc_pkg::CLS_NOISE;
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smc_pkg::ST_IDLE: if (in_fire) state_d = smc_pkg::ST_SQX;
      smc_pkg::ST_SQX:  state_d = smc_pkg::ST_SQY;
      smc_pkg::ST_SQY:  state_d = smc_pkg::ST_SQZ;
      smc_pkg::ST_SQZ:  state_d = smc_pkg::ST_RAW;
      smc_pkg::ST_RAW:  if (cnt_q == smc_pkg::SQRT_LAST) state_d = smc_pkg::ST_EMA1;
      smc_pkg::ST_EMA1: state_d = smc_pkg::ST_EMA2;
      smc_pkg::ST_EMA2: state_d = smc_pkg::ST_OLD;
      smc_pkg::ST_OLD:  state_d = smc_pkg::ST_PUSH;
      smc_pkg::ST_PUSH: state_d = smc_pkg::ST_NQ;
      smc_pkg::ST_NQ:   state_d = smc_pkg::ST_TT;
      smc_pkg::ST_TT:   state_d = smc_pkg::ST_NN;
      smc_pkg::ST_NN:   state_d = smc_pkg::ST_VAR;
      smc_pkg::ST_VAR:  if (cnt_q == smc_pkg::VAR_LAST) state_d = smc_pkg::ST_SD;
      smc_pkg::ST_SD:   if (cnt_q == smc_pkg::SQRT_LAST) state_d = smc_pkg::ST_MEAN;
      smc_pkg::ST_MEAN: if (cnt_q == smc_pkg::MEAN_LAST) state_d = smc_pkg::ST_KSD;
      smc_pkg::ST_KSD:  state_d = smc_pkg::ST_STEP;
      smc_pkg::ST_STEP: if (out_free) state_d = smc_pkg::ST_IDLE;
      default:          state_d = smc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Control state: statistics, flight, holdoff, history and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_q          <= smc_pkg::ONE_G;
      prior_q        <= smc_pkg::ONE_G;
      older_q        <= smc_pkg::ONE_G;
      fill_q         <= '0;
      head_q         <= '0;
      total_q        <= '0;
      sq_total_q     <= '0;
      airborne_q     <= 1'b0;
      flight_start_q <= '0;
      exit_cnt_q     <= '0;
      holdoff_end_q  <= '0;
      out_valid_q    <= 1'b0;
      cnt_q          <= '0;
    end else begin
      // In the decision step the output register is refilled instead.
      if (out_valid_q && out_ch_o.ready && (state_q != smc_pkg::ST_STEP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        smc_pkg::ST_SQZ: cnt_q <= '0;
        smc_pkg::ST_RAW, smc_pkg::ST_VAR, smc_pkg::ST_SD, smc_pkg::ST_MEAN: begin
          if ((state_q == smc_pkg::ST_VAR && cnt_q == smc_pkg::VAR_LAST) ||
              (state_q != smc_pkg::ST_VAR && cnt_q == smc_pkg::SQRT_LAST)) begin
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        smc_pkg::ST_NN: cnt_q <= '0;
        smc_pkg::ST_EMA2: begin
          ema_q <= smooth_n;
          if (!airborne_q) begin
            if (raw_q < enter_q) begin
              airborne_q     <= 1'b1;
              flight_start_q <= t_q;
              exit_cnt_q     <= '0;
            end
          end else if (landing) begin
            airborne_q <= 1'b0;
            exit_cnt_q <= '0;
          end else begin
            exit_cnt_q <= exit_inc;
          end
        end
        smc_pkg::ST_OLD: begin
          if (full) begin
            total_q <= total_q - TW'(old_entry);
          end
        end
        smc_pkg::ST_PUSH: begin
          total_q    <= total_q + TW'(smooth_q);
          sq_total_q <= sq_total_q - (full ? acc_q[QW-1:0] : '0) + QW'(prod);
          if (!full) begin
            fill_q <= fill_q + NW'(1);
          end
          head_q <= (head_q == HW'(WINDOW_LEN - 1)) ? '0 : head_q + HW'(1);
        end
        smc_pkg::ST_STEP: begin
          if (out_free) begin
            older_q     <= prior_q;
            prior_q     <= smooth_q;
            out_valid_q <= 1'b1;
            if (step_hit) begin
              holdoff_end_q <= t_q + 32'(holdoff_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ax_q <= in_ch_i.accel_x[15] ? 16'(-in_ch_i.accel_x) : 16'(in_ch_i.accel_x);
      ay_q <= in_ch_i.accel_y[15] ? 16'(-in_ch_i.accel_y) : 16'(in_ch_i.accel_y);
      az_q <= in_ch_i.accel_z[15] ? 16'(-in_ch_i.accel_z) : 16'(in_ch_i.accel_z);
      t_q  <= in_ch_i.time_ms;
    end
    case (state_q)
      smc_pkg::ST_SQX: acc_q <= AW'(prod);
      smc_pkg::ST_SQY: acc_q <= acc_q + AW'(prod);
      smc_pkg::ST_SQZ: begin
        s_q    <= 32'(acc_q + AW'(prod));
        feed_q <= 32'(acc_q + AW'(prod));
        rem_q  <= '0;
        quo_q  <= '0;
      end
      smc_pkg::ST_RAW: begin
        rem_q  <= rem_n;
        quo_q  <= quo_n;
        feed_q <= feed_n;
        if (cnt_q == smc_pkg::SQRT_LAST) begin
          raw_q <= quo_n[15:0];
        end
      end
      smc_pkg::ST_EMA1: acc_q <= AW'(prod);
      smc_pkg::ST_EMA2: begin
        smooth_q <= smooth_n;
        jump_q   <= airborne_q && landing &&
                    (flight_dur >= 32'(min_ms_q)) && (flight_dur <= 32'(max_ms_q));
      end
      smc_pkg::ST_OLD: acc_q <= AW'(prod);
      smc_pkg::ST_NQ:  acc_q <= AW'(prod);
      smc_pkg::ST_TT:  acc_q <= acc_q - AW'(prod);
      smc_pkg::ST_NN: begin
        // The variance stays below 2^31, so the top of the numerator is already
        // smaller than n*n and only 31 quotient bits remain to be found.
        nn_q   <= prod[2*NW-1:0];
        rem_q  <= UW'(acc_q >> 31);
        feed_q <= {acc_q[30:0], 1'b0};
        quo_q  <= '0;
      end
      smc_pkg::ST_VAR: begin
        if (cnt_q == smc_pkg::VAR_LAST) begin
          rem_q  <= '0;
          feed_q <= quo_n;
          quo_q  <= '0;
        end else begin
          rem_q  <= rem_n;
          quo_q  <= quo_n;
          feed_q <= feed_n;
        end
      end
      smc_pkg::ST_SD: begin
        if (cnt_q == smc_pkg::SQRT_LAST) begin
          sd_q   <= quo_n[15:0];
          rem_q  <= UW'(total_q[TW-1:16]);
          feed_q <= {total_q[15:0], 16'd0};
          quo_q  <= '0;
        end else begin
          rem_q  <= rem_n;
          quo_q  <= quo_n;
          feed_q <= feed_n;
        end
      end
      smc_pkg::ST_MEAN: begin
        rem_q  <= rem_n;
        quo_q  <= quo_n;
        feed_q <= feed_n;
        if (cnt_q == smc_pkg::MEAN_LAST) begin
          mean_q <= quo_n[15:0];
        end
      end
      smc_pkg::ST_KSD: acc_q <= AW'(prod);
      smc_pkg::ST_STEP: begin
        if (out_free) begin
          out_class_q <= cls;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_exit_cnt_below_landing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_cnt_q != smc_pkg::LANDING_SAMPLES)
    else $error("landing counter held its terminal value");

  a_grounded_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !airborne_q |-> exit_cnt_q == 2'd0)
    else $error("landing counter non-zero while grounded");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= NW'(WINDOW_LEN))
    else $error("window fill beyond its depth");

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == smc_pkg::ST_SQX)
    else $error("accepted sample did not start the sequencer");

  a_result_from_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == smc_pkg::ST_STEP)
    else $error("class word raised outside the decision step");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench of the step and jump motion classifier core.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  smc_in_if  in_ch();
  smc_out_if out_ch();

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  step_and_jump_motion_classifier_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch_i(in_ch.sink), .out_ch_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // The clock runs at 50 MHz.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [15:0] cfg_enter, cfg_exit, cfg_min_ms, cfg_max_ms;
  logic [9:0]  cfg_k_gain;
  logic [15:0] cfg_floor, cfg_ceiling, cfg_holdoff;

  // Shadow copy of the classifier state.
  logic [15:0] sh_ema, sh_prior, sh_older;
  logic [15:0] sh_window [smc_pkg::WINDOW_LEN_DEF];
  int unsigned sh_fill, sh_head;
  logic [63:0] sh_total, sh_sq_total;
  bit          sh_airborne;
  logic [31:0] sh_flight_start, sh_holdoff_end;
  int unsigned sh_exit_count;

  smc_pkg::motion_class_e expected_classes[$];
  int unsigned   error_count = 0;
  int unsigned   idle_cycles = 0;
  bit            no_stall = 1'b0;
  logic [31:0]   clock_ms = 32'd0;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 200;

  // Bit-serial integer square root, floor of the result.
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic reset_shadow();
    cfg_enter = smc_pkg::RST_ENTER; cfg_exit = smc_pkg::RST_EXIT;
    cfg_min_ms = smc_pkg::RST_MIN_MS; cfg_max_ms = smc_pkg::RST_MAX_MS;
    cfg_k_gain = smc_pkg::RST_K_GAIN; cfg_floor = smc_pkg::RST_FLOOR;
    cfg_ceiling = smc_pkg::RST_CEILING; cfg_holdoff = smc_pkg::RST_HOLDOFF;
    sh_ema = smc_pkg::ONE_G; sh_prior = smc_pkg::ONE_G; sh_older = smc_pkg::ONE_G;
    foreach (sh_window[i]) sh_window[i] = '0;
    sh_fill = 0; sh_head = 0; sh_total = 0; sh_sq_total = 0;
    sh_airborne = 0; sh_flight_start = 0; sh_exit_count = 0; sh_holdoff_end = 0;
  endtask

  // Works out the class of one sample and advances the shadow state.
  function automatic smc_pkg::motion_class_e classify_sample(
      input logic signed [15:0] ax, input logic signed [15:0] ay,
      input logic signed [15:0] az, input logic [31:0] t);
    logic [63:0] sq, root, mean, var_q, sd, thr, clamped, smooth64, old, n;
    logic [15:0] raw, smooth;
    logic [31:0] dur;
    bit jump, step, peak;
    jump = 0;
    step = 0;
    sq = 64'(longint'(ax) * ax) + 64'(longint'(ay) * ay) + 64'(longint'(az) * az);
    root = int_sqrt(sq);
    raw = (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
    smooth64 = (64'(smc_pkg::ALPHA_NEW) * raw + 64'(smc_pkg::ALPHA_OLD) * sh_ema
                + 64'd32768) >> 16;
    smooth = (smooth64 > 64'hFFFF) ? 16'hFFFF : smooth64[15:0];
    sh_ema = smooth;

    // Flight detection works on the raw magnitude.
    if (!sh_airborne) begin
      if (raw < cfg_enter) begin
        sh_airborne = 1;
        sh_flight_start = t;
        sh_exit_count = 0;
      end
    end else begin
      if (raw > cfg_exit) begin
        if (sh_exit_count < smc_pkg::LANDING_SAMPLES) sh_exit_count++;
      end else begin
        sh_exit_count = 0;
      end
      if (sh_exit_count >= smc_pkg::LANDING_SAMPLES) begin
        dur = t - sh_flight_start;
        sh_airborne = 0;
        sh_exit_count = 0;
        jump = (dur >= cfg_min_ms) && (dur <= cfg_max_ms);
      end
    end

    // Sliding window statistics on the smoothed magnitude.
    if (sh_fill >= smc_pkg::WINDOW_LEN_DEF) begin
      old = sh_window[sh_head];
      sh_total = sh_total - old;
      sh_sq_total = sh_sq_total - old * old;
    end else begin
      sh_fill++;
    end
    sh_window[sh_head] = smooth;
    sh_total = sh_total + smooth;
    sh_sq_total = sh_sq_total + 64'(smooth) * smooth;
    sh_head = (sh_head + 1) % smc_pkg::WINDOW_LEN_DEF;
    n = sh_fill;
    mean = sh_total / n;
    var_q = (n * sh_sq_total - sh_total * sh_total) / (n * n);
    sd = int_sqrt(var_q);
    thr = mean + ((64'(cfg_k_gain) * sd) >> 8);
    clamped = (thr < cfg_ceiling) ? thr : 64'(cfg_ceiling);
    if (clamped < cfg_floor) clamped = cfg_floor;
    peak = (sh_prior > sh_older) && (sh_prior > smooth);
    sh_older = sh_prior;
    if (peak && (sh_prior > clamped) && (t > sh_holdoff_end)) begin
      sh_holdoff_end = t + cfg_holdoff;
      step = 1;
    end
    sh_prior = smooth;

    if (jump) return smc_pkg::CLS_JUMP;
    if (step) return smc_pkg::CLS_STEP;
    if (sq > smc_pkg::IDLE_LOW_SQ && sq < smc_pkg::IDLE_HIGH_SQ) return smc_pkg::CLS_IDLE;
    return smc_pkg::CLS_NOISE;
  endfunction

  function automatic bit idle_now();
    return !no_stall && ($urandom_range(99) < 31);
  endfunction

  // Sends one sample word, predicting its class when it is accepted. Valid stays high
  // after acceptance until the next call either replaces the word or idles.
  task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                             input logic signed [15:0] az, input logic [31:0] t);
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.accel_x <= ax;
    in_ch.accel_y <= ay;
    in_ch.accel_z <= az;
    in_ch.time_ms <= t;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_classes.push_back(classify_sample(ax, ay, az, t));
  endtask

  // Sample at a given magnitude on z, time advancing by dt.
  task automatic send_z(input logic signed [15:0] az, input int unsigned dt);
    clock_ms = clock_ms + dt;
    send_sample(16'sd0, 16'sd0, az, clock_ms);
  endtask

  // Waits until every class word has arrived and the sequencer has settled.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_classes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input smc_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      smc_pkg::REG_ENTER:   cfg_enter   = value[15:0];
      smc_pkg::REG_EXIT:    cfg_exit    = value[15:0];
      smc_pkg::REG_MIN_MS:  cfg_min_ms  = value[15:0];
      smc_pkg::REG_MAX_MS:  cfg_max_ms  = value[15:0];
      smc_pkg::REG_K_GAIN:  cfg_k_gain  = value[9:0];
      smc_pkg::REG_FLOOR:   cfg_floor   = value[15:0];
      smc_pkg::REG_CEILING: cfg_ceiling = value[15:0];
      smc_pkg::REG_HOLDOFF: cfg_holdoff = value[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] enter, input logic [15:0] exit_lvl,
                           input logic [15:0] min_ms, input logic [15:0] max_ms,
                           input logic [9:0] k_gain, input logic [15:0] floor_lvl,
                           input logic [15:0] ceiling, input logic [15:0] holdoff);
    wait_drained();
    write_reg(smc_pkg::REG_ENTER, enter);
    write_reg(smc_pkg::REG_EXIT, exit_lvl);
    write_reg(smc_pkg::REG_MIN_MS, min_ms);
    write_reg(smc_pkg::REG_MAX_MS, max_ms);
    write_reg(smc_pkg::REG_K_GAIN, k_gain);
    write_reg(smc_pkg::REG_FLOOR, floor_lvl);
    write_reg(smc_pkg::REG_CEILING, ceiling);
    write_reg(smc_pkg::REG_HOLDOFF, holdoff);
  endtask

  // Extremes of the axes, idle band edges, a jump, steps and a timestamp wrap in flight.
  task automatic test_directed();
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd0);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF);
    send_sample(16'sh8000, 16'sh7FFF, 16'sd0, 32'd5);
    send_sample(16'sd0, 16'sd0, 16'sd0, 32'd10);
    // Idle band edges: 1843 and 2253 lie just outside, 1844 and 2252 just inside.
    send_sample(16'sd0, 16'sd1843, 16'sd0, 32'd20);
    send_sample(16'sd1844, 16'sd0, 16'sd0, 32'd30);
    send_sample(16'sd0, 16'sd0, 16'sd2252, 32'd40);
    send_sample(16'sd0, 16'sd0, 16'sd2253, 32'd50);
    clock_ms = 32'd100;
    // Flight, begun at the zero sample above, then three landing samples: a jump.
    send_z(16'sd100, 10);
    repeat (3) send_z(16'sd200, 100);
    repeat (3) send_z(16'sd8000, 10);
    // Step peaks.
    repeat (3) begin
      send_z(16'sd2048, 100);
      send_z(16'sd7000, 100);
      send_z(16'sd2048, 100);
    end
    // Timestamp wrap during flight.
    clock_ms = 32'hFFFF_FF00;
    send_z(16'sd0, 0);
    repeat (3) send_z(16'sd9000, 100);
  endtask

  // Well-formed walking and jumping with random content, plus noise.
  task automatic test_random(input int unsigned count);
    int unsigned kind, i, amp;
    for (i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      no_stall = (i >= count / 3) && (i < count / 3 + 60);
      if (kind < 40) begin
        amp = $urandom_range(6000);
        send_z(16'(2048 + $signed(amp) - 3000), $urandom_range(150));
      end else if (kind < 60) begin
        send_z(16'sd2048 + 16'($urandom_range(400)), $urandom_range(120));
        send_z(16'($urandom_range(9000, 3000)), $urandom_range(120));
        send_z(16'sd2048 - 16'($urandom_range(800)), $urandom_range(120));
      end else if (kind < 72) begin
        send_z(16'($urandom_range(600)), $urandom_range(50));
        repeat ($urandom_range(6)) send_z(16'($urandom_range(900)), $urandom_range(200));
        repeat ($urandom_range(3, 2)) send_z(16'($urandom_range(12000, 3500)),
                                             $urandom_range(40));
        send_z(16'sd2048, $urandom_range(40));
      end else if (kind < 80) begin
        clock_ms = clock_ms + $urandom;
        send_sample(16'($urandom), 16'($urandom), 16'($urandom), clock_ms);
      end else begin
        send_sample(16'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end
    end
    no_stall = 1'b0;
  endtask

  // Receiver: random back-pressure and the comparison of each class word.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_classes.size() == 0) begin
          $error("motion_class: no class word expected, got %0d", out_ch.motion_class);
          error_count++;
        end else begin
          smc_pkg::motion_class_e exp_cls;
          exp_cls = expected_classes.pop_front();
          if (out_ch.motion_class !== exp_cls) begin
            $error("motion_class: expected %0d, actual %0d", exp_cls, out_ch.motion_class);
            error_count++;
          end
        end
      end
      out_ch.ready <= !idle_now();
    end
  end

  // Watchdog on cycles with no accepted word on either channel and no register access.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    in_ch.time_ms = '0;
    out_ch.ready  = 1'b0;
    reset_shadow();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(130);
    write_all(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 10'h3FF, 16'd0, 16'hFFFF, 16'd0);
    test_random(90);
    write_all(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 10'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    test_random(50);
    write_all(16'd1000, 16'd2800, 16'd50, 16'd2000, 10'd128, 16'd2100, 16'd6000, 16'd150);
    test_random(130);

    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
